@@ rtl/gf2_poly_mul_mod_assert.svh @@
// Assertion macros for the GF(2) polynomial multiply/reduce unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GF2_POLY_MUL_MOD_ASSERT_SVH
`define GF2_POLY_MUL_MOD_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gpm_pkg.sv @@
// Shared types and constants for the GF(2) polynomial multiply/reduce unit.
// No dependencies.
`default_nettype none

package gpm_pkg;

    localparam int POLY_WIDTH = 32;                 // used polynomial bits, 8..32
    localparam int DIV_W      = 2 * POLY_WIDTH - 1; // full product / dividend width
    localparam int IDX_W      = $clog2(POLY_WIDTH);
    localparam int STEP_W     = $clog2(DIV_W);

    localparam int OPER_W = 32;
    localparam int REM_W  = 32;
    localparam int QUO_W  = 63;
    localparam int DEG_W  = 7;

    localparam logic [DEG_W-1:0] DEG_NONE = '1;     // degree of the zero polynomial

    localparam logic [1:0] OP_DEGREE = 2'd0;
    localparam logic [1:0] OP_REDUCE = 2'd1;
    localparam logic [1:0] OP_MULMOD = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [OPER_W-1:0] operand_a;
        logic [OPER_W-1:0] operand_b;
    } cmd_t;

    typedef struct packed {
        logic [REM_W-1:0] remainder;
        logic [QUO_W-1:0] quotient;
        logic [DEG_W-1:0] degree;
        logic             bad_field;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/gf2_poly_mul_mod.sv @@
// GF(2) polynomial unit: degree, reduction modulo the field polynomial, and
// multiply-then-reduce. Depends on gpm_pkg and gf2_poly_mul_mod_assert.svh.
//
// Usage:
//   Command channel: an item (cmd) is taken at a clock edge with start high
//   and busy low. busy stays high while the item is worked on.
//   Result channel: done is high for one cycle with the result on result;
//   the receiver must take it then, it cannot hold results off.
//   Config channel: cfg_data is written to field_poly when cfg_valid and
//   cfg_ready are both high. cfg_ready is low while busy or while start is
//   high. After a write the unit finds the field degree in its scan state,
//   with busy high.
// Steps (POLY_WIDTH = 32), from accept to done:
//   degree op: a scan of operand_a, one shift-and-test per cycle;
//   reduce op: 32 division steps, then a scan of the remainder;
//   multiply op: 32 multiply steps, 63 division steps, then the scan;
//   zero field polynomial or unused op: answered from idle, busy stays low.
// One item at a time; the shared shift/xor datapath and the degree scanner
// each handle one bit per cycle.
// Reset clears field_poly to zero and returns the sequencer to idle.
`default_nettype none
`include "gf2_poly_mul_mod_assert.svh"

module gf2_poly_mul_mod (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire gpm_pkg::cmd_t    cmd,
    output logic                  done,
    output gpm_pkg::result_t      result,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [31:0]      cfg_data
);
    import gpm_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FSCAN = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;

    localparam logic [IDX_W-1:0]  IDX_TOP  = IDX_W'(POLY_WIDTH - 1);
    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(POLY_WIDTH - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

    logic [2:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic [31:0]           field_reg, field_next;
    logic [IDX_W-1:0]      fd_reg, fd_next;

    logic [1:0]            op_reg, op_next;
    logic [POLY_WIDTH-1:0] a_reg, a_next;
    logic [POLY_WIDTH-1:0] b_reg, b_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [POLY_WIDTH-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]      quo_reg, quo_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [POLY_WIDTH-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    result_t               res_reg, res_next;

    logic [POLY_WIDTH-1:0] fpoly;
    logic                  fzero;
    logic                  scan_zero;
    logic                  scan_hit;
    logic [POLY_WIDTH-1:0] r_sh;
    logic                  q_bit;
    logic [DEG_W-1:0]      scan_deg;
    result_t               res_bad;
    result_t               res_none;

    assign fpoly     = field_reg[POLY_WIDTH-1:0];
    assign fzero     = (fpoly == '0);
    assign scan_zero = (scan_reg == '0);
    assign scan_hit  = scan_reg[POLY_WIDTH-1];
    assign scan_deg  = scan_zero ? DEG_NONE : DEG_W'(cnt_reg);

    // One long-division step: bring down the next dividend bit, subtract on hit.
    assign r_sh  = {rem_reg[POLY_WIDTH-2:0], div_reg[DIV_W-1]};
    assign q_bit = r_sh[fd_reg];

    assign res_bad  = '{remainder: '0, quotient: '0, degree: DEG_NONE, bad_field: 1'b1};
    assign res_none = '{remainder: '0, quotient: '0, degree: DEG_NONE, bad_field: 1'b0};

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy && !start;
    assign done      = done_reg;
    assign result    = res_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        field_next = field_reg;
        fd_next    = fd_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        scan_next  = scan_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    field_next = cfg_data;
                    scan_next  = cfg_data[POLY_WIDTH-1:0];
                    cnt_next   = IDX_TOP;
                    state_next = ST_FSCAN;
                end
                else if (start)
                begin
                    op_next = cmd.op;
                    a_next  = cmd.operand_a[POLY_WIDTH-1:0];
                    b_next  = cmd.operand_b[POLY_WIDTH-1:0];
                    case (cmd.op)
                        OP_DEGREE:
                        begin
                            scan_next  = cmd.operand_a[POLY_WIDTH-1:0];
                            cnt_next   = IDX_TOP;
                            state_next = ST_SCAN;
                        end
                        OP_REDUCE:
                        begin
                            if (fzero)
                            begin
                                done_next = 1'b1;
                                res_next  = res_bad;
                            end
                            else
                            begin
                                // align A to the top of the dividend, POLY_WIDTH steps
                                div_next   = {cmd.operand_a[POLY_WIDTH-1:0],
                                              (POLY_WIDTH-1)'(0)};
                                rem_next   = '0;
                                quo_next   = '0;
                                step_next  = MUL_LAST;
                                state_next = ST_DIV;
                            end
                        end
                        OP_MULMOD:
                        begin
                            if (fzero)
                            begin
                                done_next = 1'b1;
                                res_next  = res_bad;
                            end
                            else
                            begin
                                div_next   = '0;
                                rem_next   = '0;
                                quo_next   = '0;
                                step_next  = MUL_LAST;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            res_next  = res_none;
                        end
                    endcase
                end
            end

            ST_FSCAN:
            begin
                if (scan_zero || scan_hit)
                begin
                    fd_next    = cnt_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg << 1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            ST_MUL:
            begin
                // MSB-first shift-and-xor product, accumulated in the dividend
                div_next = (div_reg << 1) ^ (b_reg[POLY_WIDTH-1] ? DIV_W'(a_reg) : '0);
                b_next   = b_reg << 1;
                if (step_reg == '0)
                begin
                    step_next  = DIV_LAST;
                    state_next = ST_DIV;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_DIV:
            begin
                rem_next = q_bit ? (r_sh ^ fpoly) : r_sh;
                quo_next = {quo_reg[DIV_W-2:0], q_bit};
                div_next = div_reg << 1;
                if (step_reg == '0)
                begin
                    scan_next  = rem_next;
                    cnt_next   = IDX_TOP;
                    state_next = ST_SCAN;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            ST_SCAN:
            begin
                if (scan_zero || scan_hit)
                begin
                    done_next           = 1'b1;
                    res_next.degree     = scan_deg;
                    res_next.bad_field  = 1'b0;
                    if (op_reg == OP_DEGREE)
                    begin
                        res_next.remainder = '0;
                        res_next.quotient  = '0;
                    end
                    else
                    begin
                        res_next.remainder = REM_W'(rem_reg);
                        res_next.quotient  = QUO_W'(quo_reg);
                    end
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg << 1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            field_reg <= '0;
            fd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            field_reg <= field_next;
            fd_reg    <= fd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
        scan_reg <= scan_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    `GPM_ASSERT_IMP(a_done_idle, done, !busy, "result strobed while still busy")
    `GPM_ASSERT_NXT(a_cfg_scan, cfg_valid && cfg_ready, busy, "no field scan after config write")
    `GPM_ASSERT_IMP(a_bad_clean, done && result.bad_field,
                    (result.remainder == '0) && (result.quotient == '0)
                    && (result.degree == DEG_NONE), "bad field result not cleared")
    `GPM_ASSERT_IMP(a_rem_bound, state_reg == ST_DIV, (rem_reg >> fd_reg) == '0,
                    "partial remainder reached field degree")

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for gf2_poly_mul_mod: degree, reduce and multiply-reduce items checked
// against an in-bench GF(2) predictor under several field polynomials.
// Depends on gpm_pkg and the gf2_poly_mul_mod RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpm_pkg::*;

    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam logic [63:0] POLY_MASK  = (64'd1 << POLY_WIDTH) - 64'd1;
    localparam int          ITEMS_PER_PHASE = 136;
    localparam int          NUM_PHASES      = 12;
    localparam int          SETTLE_CYCLES   = 160;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    result_t     pending_results[$];
    logic [31:0] cur_field;
    int          error_count;
    int          burst_left;

    gf2_poly_mul_mod DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Degree of a polynomial, -1 for zero.
    function automatic int poly_deg(input logic [63:0] p);
        int d;
        d = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (p[i])
                d = i;
        end
        return d;
    endfunction

    function automatic result_t gf2_outcome(input cmd_t c, input logic [31:0] field);
        result_t     res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] f;
        logic [63:0] dividend;
        logic [63:0] q;
        logic [63:0] r;
        int          fd;
        int          rd;
        int          dg;
        a = {32'd0, c.operand_a} & POLY_MASK;
        b = {32'd0, c.operand_b} & POLY_MASK;
        f = {32'd0, field} & POLY_MASK;
        res.remainder = '0;
        res.quotient  = '0;
        res.degree    = DEG_NONE;
        res.bad_field = 1'b0;
        if (c.op == OP_DEGREE)
        begin
            dg = poly_deg(a);
            res.degree = dg[DEG_W-1:0];
        end
        else if (c.op == OP_REDUCE || c.op == OP_MULMOD)
        begin
            if (f == 64'd0)
                res.bad_field = 1'b1;
            else
            begin
                dividend = 64'd0;
                if (c.op == OP_REDUCE)
                    dividend = a;
                else
                begin
                    // carry-less product
                    for (int i = 0; i < POLY_WIDTH; i++)
                    begin
                        if (b[i])
                            dividend ^= a << i;
                    end
                end
                fd = poly_deg(f);
                q  = 64'd0;
                r  = dividend;
                rd = poly_deg(r);
                while (rd >= fd)
                begin
                    q  |= 64'd1 << (rd - fd);
                    r  ^= f << (rd - fd);
                    rd  = poly_deg(r);
                end
                res.remainder = r[REM_W-1:0];
                res.quotient  = q[QUO_W-1:0];
                res.degree    = rd[DEG_W-1:0];
            end
        end
        return res;
    endfunction

    // Check each result against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.remainder !== want.remainder)
                begin
                    $display("%0t: remainder mismatch, expected %h, actual %h",
                             $time, want.remainder, result.remainder);
                    error_count++;
                end
                if (result.quotient !== want.quotient)
                begin
                    $display("%0t: quotient mismatch, expected %h, actual %h",
                             $time, want.quotient, result.quotient);
                    error_count++;
                end
                if (result.degree !== want.degree)
                begin
                    $display("%0t: degree mismatch, expected %h, actual %h",
                             $time, want.degree, result.degree);
                    error_count++;
                end
                if (result.bad_field !== want.bad_field)
                begin
                    $display("%0t: bad_field mismatch, expected %b, actual %b",
                             $time, want.bad_field, result.bad_field);
                    error_count++;
                end
            end
        end
    end

    // Hold start high until the item is taken; start stays high for a following item.
    task automatic send_cmd(input logic [1:0] op, input logic [31:0] a, input logic [31:0] b);
        cmd_t c;
        c.op        = op;
        c.operand_a = a;
        c.operand_b = b;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(gf2_outcome(c, cur_field));
    endtask

    task automatic pause_sender(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_field(input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_field = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_poly();
        logic [63:0] m;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3, 4:
            begin
                m = (64'd1 << $urandom_range(1, 32)) - 64'd1;
                return $urandom & m[31:0];
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [1:0] rand_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)
            return OP_DEGREE;
        else if (r < 11)
            return OP_REDUCE;
        else if (r < 19)
            return OP_MULMOD;
        else
            return OP_UNUSED;
    endfunction

    // Reset value of field_poly is zero: reducing ops must flag it.
    task automatic test_zero_field();
        send_cmd(OP_REDUCE, 32'h1234_5678, 32'd0);
        send_cmd(OP_MULMOD, '1, '1);
        send_cmd(OP_DEGREE, 32'h0000_8000, 32'd0);
        send_cmd(OP_UNUSED, '1, '1);
    endtask

    // Field of one: remainder zero, quotient equals the dividend.
    task automatic test_unit_field();
        write_field(32'd1);
        send_cmd(OP_REDUCE, '1, 32'd0);
        send_cmd(OP_MULMOD, '1, '1);
        send_cmd(OP_DEGREE, '1, '1);
        send_cmd(OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    endtask

    task automatic test_extremes();
        write_field('1);
        send_cmd(OP_DEGREE, 32'd0, 32'd0);
        send_cmd(OP_DEGREE, 32'd1, '1);
        send_cmd(OP_REDUCE, 32'd0, 32'd0);
        send_cmd(OP_REDUCE, '1, 32'd0);
        send_cmd(OP_MULMOD, '1, '1);
        send_cmd(OP_MULMOD, 32'd0, '1);
        send_cmd(OP_MULMOD, '1, 32'd0);
        write_field(32'h8000_0000);
        send_cmd(OP_REDUCE, '1, 32'd0);
        send_cmd(OP_MULMOD, '1, '1);
        send_cmd(OP_MULMOD, 32'h8000_0000, 32'h8000_0000);
        write_field(32'h0000_011B);
        send_cmd(OP_MULMOD, 32'h0000_0057, 32'h0000_0083);
        send_cmd(OP_REDUCE, 32'h0000_00FF, 32'd0);
        send_cmd(OP_UNUSED, 32'd0, 32'd0);
    endtask

    // Random items over a series of field settings, sender in bursts on most phases.
    task automatic test_random();
        logic [31:0] field;
        bit          gaps_on;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0: field = '1;
                1: field = 32'd1;
                2: field = 32'h8000_0000;
                3: field = 32'd0;
                4: field = 32'd3;
                default: field = ($urandom | (32'd1 << $urandom_range(0, 31)))
                                 & ((32'd2 << $urandom_range(0, 31)) - 32'd1);
            endcase
            if (field == 32'd0 && phase != 3)
                field = 32'd1;
            write_field(field);
            gaps_on    = (phase % 3) != 1;
            burst_left = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (gaps_on)
                begin
                    if (burst_left == 0)
                    begin
                        pause_sender($urandom_range(1, 12));
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                end
                send_cmd(rand_op(), rand_poly(), rand_poly());
                // drop start now and then and let everything drain
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        cur_field   = '0;
        error_count = 0;
        burst_left  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_field();
        test_unit_field();
        test_extremes();
        test_random();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #15ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
